### hw/rtl/kdlp_pkg.sv
`timescale 1ns / 1ps

package kdlp_pkg;

  // Default matrix geometry
  localparam int KeyRowsDef = 4;
  localparam int KeyColsDef = 4;

  // Fixed field widths
  localparam int OpW     = 2;
  localparam int RowW    = 2;
  localparam int LevelsW = 4;
  localparam int KeyW    = 4;
  localparam int CountW  = 8;
  localparam int FlagsW  = 16;
  localparam int CfgIdxW = 1;
  localparam int CfgW    = 8;

  // Register reset values
  localparam logic [CountW-1:0] LongPressReset = 8'd150;
  localparam logic [CountW-1:0] RepeatReset    = 8'd25;

  // Queue depth between stages
  localparam int QueueDepthDef = 2;

  typedef enum logic [OpW-1:0] {
    OP_SCAN       = 2'd0,
    OP_TEST_PRESS = 2'd1,
    OP_TEST_LONG  = 2'd2,
    OP_UNUSED     = 2'd3
  } op_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_LONG_PRESS = 1'b0,
    CFG_REPEAT     = 1'b1
  } cfg_idx_e;

  // Per-key mode machine, one-hot
  typedef enum logic [2:0] {
    MODE_RELEASED = 3'b001,
    MODE_PRESSED  = 3'b010,
    MODE_LONG     = 3'b100
  } mode_e;

  // Classified command from the front end
  typedef struct packed {
    logic               scan;        // valid row scan
    logic               test_press;  // press flag test on an existing key
    logic               test_long;   // long flag test on an existing key
    logic [RowW-1:0]    row;
    logic [LevelsW-1:0] levels;
    logic [KeyW-1:0]    key;
  } cmd_t;

  typedef struct packed {
    logic [FlagsW-1:0] press_flags;
    logic [FlagsW-1:0] long_flags;
    logic              hit;
  } res_t;

endpackage

### hw/rtl/kdlp_fifo.sv
`timescale 1ns / 1ps

module kdlp_fifo #(
  parameter int Width = 8,
  parameter int Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] data_o,
  output logic             empty_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

### hw/rtl/kdlp_front.sv
`timescale 1ns / 1ps

module kdlp_front #(
  parameter int KeyRows = kdlp_pkg::KeyRowsDef,
  parameter int KeyCols = kdlp_pkg::KeyColsDef
) (
  input  logic [kdlp_pkg::OpW-1:0]     operation_i,
  input  logic [kdlp_pkg::RowW-1:0]    row_i,
  input  logic [kdlp_pkg::LevelsW-1:0] column_levels_i,
  input  logic [kdlp_pkg::KeyW-1:0]    key_i,
  output kdlp_pkg::cmd_t               cmd_o
);

  import kdlp_pkg::*;

  localparam int KeyTotal = KeyRows * KeyCols;

  logic row_ok, key_ok;

  assign row_ok = int'(row_i) < KeyRows;
  assign key_ok = int'(key_i) < KeyTotal;

  // Out-of-range rows and keys fold into no-op commands here
  always_comb begin
    cmd_o            = '0;
    cmd_o.row        = row_i;
    cmd_o.levels     = column_levels_i;
    cmd_o.key        = key_i;
    unique case (op_e'(operation_i))
      OP_SCAN:       cmd_o.scan       = row_ok;
      OP_TEST_PRESS: cmd_o.test_press = key_ok;
      OP_TEST_LONG:  cmd_o.test_long  = key_ok;
      default:       cmd_o.scan       = 1'b0;
    endcase
  end

endmodule

### hw/rtl/kdlp_back.sv
`timescale 1ns / 1ps

module kdlp_back #(
  parameter int KeyRows = kdlp_pkg::KeyRowsDef,
  parameter int KeyCols = kdlp_pkg::KeyColsDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [kdlp_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [kdlp_pkg::CfgW-1:0]    cfg_data_i,
  input  logic                         cmd_valid_i,
  input  kdlp_pkg::cmd_t               cmd_i,
  output logic                         cmd_take_o,
  input  logic                         res_full_i,
  output logic                         res_push_o,
  output kdlp_pkg::res_t               res_o
);

  import kdlp_pkg::*;

  localparam int KeyTotal = KeyRows * KeyCols;
  localparam int KIdxW    = (KeyTotal > 1) ? $clog2(KeyTotal) : 1;
  localparam int KExtW    = KIdxW + KeyW;

  logic [CountW-1:0] long_ticks_q, repeat_ticks_q;

  logic              last_q [KeyTotal];
  logic              last_d [KeyTotal];
  mode_e             mode_q [KeyTotal];
  mode_e             mode_d [KeyTotal];
  logic [CountW-1:0] cnt_q  [KeyTotal];
  logic [CountW-1:0] cnt_d  [KeyTotal];

  logic [KeyTotal-1:0] press_q, press_d, press_set;
  logic [KeyTotal-1:0] long_q, long_d, long_set;
  logic [KeyTotal-1:0] sel, sample;

  logic              step_en, hit;
  logic [KExtW-1:0]  key_ext;
  logic [KIdxW-1:0]  key_idx;
  logic [FlagsW-1:0] press_win, long_win;

  assign step_en    = cmd_valid_i && !res_full_i;
  assign cmd_take_o = step_en;
  assign res_push_o = step_en;

  assign key_ext = KExtW'(cmd_i.key);
  assign key_idx = key_ext[KIdxW-1:0];

  // Row decode and column sample for each key; columns past the pins read as pressed
  for (genvar k = 0; k < KeyTotal; k++) begin : g_key
    assign sel[k] = cmd_i.scan && (int'(cmd_i.row) == k / KeyCols);
    if ((k % KeyCols) < LevelsW) begin : g_pin
      assign sample[k] = cmd_i.levels[k % KeyCols];
    end else begin : g_nopin
      assign sample[k] = 1'b0;
    end
  end

  always_comb begin
    logic [CountW-1:0] inc;
    inc       = '0;
    press_set = '0;
    long_set  = '0;
    for (int k = 0; k < KeyTotal; k++) begin
      last_d[k] = last_q[k];
      mode_d[k] = mode_q[k];
      cnt_d[k]  = cnt_q[k];
      inc       = cnt_q[k] + CountW'(1);
      if (step_en && sel[k]) begin
        last_d[k] = sample[k];
        if (last_q[k] == sample[k]) begin
          unique case (mode_q[k])
            MODE_RELEASED: begin
              if (!sample[k]) mode_d[k] = MODE_PRESSED;
            end
            MODE_PRESSED: begin
              cnt_d[k] = inc;
              if (sample[k]) begin
                press_set[k] = 1'b1;
                mode_d[k]    = MODE_RELEASED;
                cnt_d[k]     = '0;
              end
              // threshold check sees the count after a release clear
              if (cnt_d[k] == long_ticks_q) begin
                mode_d[k]    = MODE_LONG;
                press_set[k] = 1'b1;
                long_set[k]  = 1'b1;
                cnt_d[k]     = '0;
              end
            end
            MODE_LONG: begin
              cnt_d[k] = inc;
              if (sample[k]) begin
                mode_d[k] = MODE_RELEASED;
                cnt_d[k]  = '0;
              end
              if (cnt_d[k] == repeat_ticks_q) begin
                press_set[k] = 1'b1;
                cnt_d[k]     = '0;
              end
            end
            default: mode_d[k] = mode_q[k];
          endcase
        end
      end
    end
  end

  // Flag test; a hit wipes every pending flag
  always_comb begin
    hit = 1'b0;
    if (cmd_i.test_press) hit = press_q[key_idx];
    if (cmd_i.test_long)  hit = long_q[key_idx];
    press_d = press_q;
    long_d  = long_q;
    if (step_en) begin
      press_d = press_q | press_set;
      long_d  = long_q | long_set;
      if (hit) begin
        press_d = '0;
        long_d  = '0;
      end
    end
  end

  for (genvar i = 0; i < FlagsW; i++) begin : g_win
    if (i < KeyTotal) begin : g_used
      assign press_win[i] = press_d[i];
      assign long_win[i]  = long_d[i];
    end else begin : g_unused
      assign press_win[i] = 1'b0;
      assign long_win[i]  = 1'b0;
    end
  end

  assign res_o.press_flags = press_win;
  assign res_o.long_flags  = long_win;
  assign res_o.hit         = hit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      long_ticks_q   <= LongPressReset;
      repeat_ticks_q <= RepeatReset;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CFG_LONG_PRESS) long_ticks_q   <= cfg_data_i;
      if (cfg_idx_i == CFG_REPEAT)     repeat_ticks_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      press_q <= '0;
      long_q  <= '0;
      for (int k = 0; k < KeyTotal; k++) begin
        last_q[k] <= 1'b0;
        mode_q[k] <= MODE_RELEASED;
        cnt_q[k]  <= '0;
      end
    end else begin
      press_q <= press_d;
      long_q  <= long_d;
      for (int k = 0; k < KeyTotal; k++) begin
        last_q[k] <= last_d[k];
        mode_q[k] <= mode_d[k];
        cnt_q[k]  <= cnt_d[k];
      end
    end
  end

endmodule

### hw/rtl/keypad_debounce_long_press.sv
`timescale 1ns / 1ps

// Key matrix scanner with debounce, long press and auto-repeat. Each scan
// transaction carries the column levels of one row (0 = pressed); a key
// steps its released/pressed/long machine only when two successive samples
// agree. Test transactions check one key's press or long flag; a hit clears
// all flags and raises beep_o with hit_o. Every input transaction yields
// exactly one result transaction, in order. Throughput is one transaction
// per cycle while the result queue has room: the back end updates all keys
// of the addressed row side by side. Each accepted transaction is registered
// in the command queue, and the back end works it into the result queue,
// whose head is what the output shows and what pop takes. Config writes
// are taken at once and belong in idle periods only.

module keypad_debounce_long_press #(
  parameter int KeyRows = kdlp_pkg::KeyRowsDef,
  parameter int KeyCols = kdlp_pkg::KeyColsDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // input queue side
  input  logic                         push,
  output logic                         full,
  input  logic [kdlp_pkg::OpW-1:0]     operation_i,
  input  logic [kdlp_pkg::RowW-1:0]    row_i,
  input  logic [kdlp_pkg::LevelsW-1:0] column_levels_i,
  input  logic [kdlp_pkg::KeyW-1:0]    key_i,
  // result queue side
  output logic                         empty,
  input  logic                         pop,
  output logic [kdlp_pkg::FlagsW-1:0]  press_flags_o,
  output logic [kdlp_pkg::FlagsW-1:0]  long_flags_o,
  output logic                         hit_o,
  output logic                         beep_o,
  // config write port
  input  logic                         cfg_we_i,
  input  logic [kdlp_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [kdlp_pkg::CfgW-1:0]    cfg_data_i
);

  import kdlp_pkg::*;

  cmd_t front_cmd, back_cmd;
  res_t back_res, out_res;
  logic cmd_empty, cmd_take;
  logic res_full, res_push;

  // Front end: classify op, turn out-of-range rows/keys into no-ops
  kdlp_front #(
    .KeyRows(KeyRows),
    .KeyCols(KeyCols)
  ) u_front (
    .operation_i    (operation_i),
    .row_i          (row_i),
    .column_levels_i(column_levels_i),
    .key_i          (key_i),
    .cmd_o          (front_cmd)
  );

  // Command queue decouples intake from execution
  kdlp_fifo #(
    .Width($bits(cmd_t)),
    .Depth(QueueDepthDef)
  ) u_cmd_q (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (front_cmd),
    .full_o (full),
    .pop_i  (cmd_take),
    .data_o (back_cmd),
    .empty_o(cmd_empty)
  );

  // Back end: key state, flags, config registers
  kdlp_back #(
    .KeyRows(KeyRows),
    .KeyCols(KeyCols)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cmd_valid_i(!cmd_empty),
    .cmd_i      (back_cmd),
    .cmd_take_o (cmd_take),
    .res_full_i (res_full),
    .res_push_o (res_push),
    .res_o      (back_res)
  );

  // Result queue absorbs consumer stalls until it fills; then intake backs up
  kdlp_fifo #(
    .Width($bits(res_t)),
    .Depth(QueueDepthDef)
  ) u_res_q (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (res_push),
    .data_i (back_res),
    .full_o (res_full),
    .pop_i  (pop),
    .data_o (out_res),
    .empty_o(empty)
  );

  assign press_flags_o = out_res.press_flags;
  assign long_flags_o  = out_res.long_flags;
  assign hit_o         = out_res.hit;
  assign beep_o        = out_res.hit;

endmodule

### hw/rtl/kdlp_checker.sv
`timescale 1ns / 1ps

module kdlp_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         push,
  input logic                         full,
  input logic                         empty,
  input logic                         pop,
  input logic [kdlp_pkg::FlagsW-1:0]  press_flags_o,
  input logic [kdlp_pkg::FlagsW-1:0]  long_flags_o,
  input logic                         hit_o,
  input logic                         beep_o
);

  // beep tracks hit on every shown result
  a_beep_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (beep_o == hit_o))
    else $error("beep differs from hit");

  // a hit clears every flag in the same result
  a_hit_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && hit_o) |-> (press_flags_o == '0 && long_flags_o == '0))
    else $error("flags left set after hit");

  // an accepted transaction is followed by a non-empty result queue
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !full) |=> ##1 !empty)
    else $error("result queue empty two cycles after push");

  // stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(press_flags_o) &&
                          $stable(long_flags_o) && $stable(hit_o)))
    else $error("stalled result changed");

endmodule

bind keypad_debounce_long_press kdlp_checker u_kdlp_checker (.*);

### sim/tb_top.sv
`timescale 1ns / 1ps

// Testbench for keypad_debounce_long_press.
// A predictor keeps its own copy of the per-key state and of the two tick
// registers. It works out the flags, hit and beep of every accepted input
// transaction. A scoreboard compares each popped result with the oldest
// prediction. Stimulus runs in phases with one register setting each: a
// directed opener, then mostly well-formed hold/release sequences with
// queries, bounce and noise mixed in.
module tb_top;
  import kdlp_pkg::*;

  localparam int NumKeys    = KeyRowsDef * KeyColsDef;
  localparam int PhaseItems = 150;   // budget per register setting
  localparam int BigStall   = 80;    // long receiver hold-off, in cycles
  localparam int NumPhases  = 9;

  // one input transaction
  typedef struct {
    op_e               op;
    logic [RowW-1:0]   row;
    logic [LevelsW-1:0] lv;
    logic [KeyW-1:0]   key;
  } keypad_item_t;

  // one result transaction
  typedef struct {
    logic [FlagsW-1:0] press;
    logic [FlagsW-1:0] lng;
    logic              hit;
  } flag_set_t;

  // DUT signals, all driven from time zero
  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                push = 1'b0;
  logic                full;
  logic [OpW-1:0]      operation_i = '0;
  logic [RowW-1:0]     row_i = '0;
  logic [LevelsW-1:0]  column_levels_i = '0;
  logic [KeyW-1:0]     key_i = '0;
  logic                empty;
  logic                pop = 1'b0;
  logic [FlagsW-1:0]   press_flags_o;
  logic [FlagsW-1:0]   long_flags_o;
  logic                hit_o;
  logic                beep_o;
  logic                cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i = '0;
  logic [CfgW-1:0]     cfg_data_i = '0;

  keypad_debounce_long_press DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .push            (push),
    .full            (full),
    .operation_i     (operation_i),
    .row_i           (row_i),
    .column_levels_i (column_levels_i),
    .key_i           (key_i),
    .empty           (empty),
    .pop             (pop),
    .press_flags_o   (press_flags_o),
    .long_flags_o    (long_flags_o),
    .hit_o           (hit_o),
    .beep_o          (beep_o),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i)
  );

  always #1 clk_i = ~clk_i;

  // ---------------------------------------------------------------------
  // Predictor state: mirrors the block's per-key registers
  // ---------------------------------------------------------------------
  logic [CountW-1:0] long_ticks = LongPressReset;
  logic [CountW-1:0] rpt_ticks  = RepeatReset;
  logic              prev_lvl [NumKeys];
  mode_e             kmode    [NumKeys];
  logic [CountW-1:0] hold_cnt [NumKeys];
  logic [FlagsW-1:0] press_pend = '0;
  logic [FlagsW-1:0] long_pend  = '0;

  initial begin
    for (int k = 0; k < NumKeys; k++) begin
      prev_lvl[k] = 1'b0;      // reset sample reads as "pressed"
      kmode[k]    = MODE_RELEASED;
      hold_cnt[k] = '0;
    end
  end

  // Apply one input transaction to the predictor, return the expected result.
  function automatic flag_set_t next_flags(op_e op, logic [RowW-1:0] row,
                                           logic [LevelsW-1:0] lv,
                                           logic [KeyW-1:0] key);
    flag_set_t res;
    int        k;
    logic      s;
    logic      hit;
    hit = 1'b0;
    if (op == OP_SCAN) begin
      for (int j = 0; j < KeyColsDef; j++) begin
        k = int'(row) * KeyColsDef + j;
        s = lv[j];
        // debounce: only step when two successive samples agree
        if (prev_lvl[k] == s) begin
          case (kmode[k])
            MODE_RELEASED: begin
              if (!s) kmode[k] = MODE_PRESSED;
            end
            MODE_PRESSED: begin
              hold_cnt[k] = hold_cnt[k] + 8'd1;
              if (s) begin
                press_pend[k] = 1'b1;
                kmode[k]      = MODE_RELEASED;
                hold_cnt[k]   = '0;
              end
              // checked after the release step, so a zero threshold fires here
              if (hold_cnt[k] == long_ticks) begin
                kmode[k]      = MODE_LONG;
                press_pend[k] = 1'b1;
                long_pend[k]  = 1'b1;
                hold_cnt[k]   = '0;
              end
            end
            MODE_LONG: begin
              hold_cnt[k] = hold_cnt[k] + 8'd1;
              if (s) begin
                kmode[k]    = MODE_RELEASED;
                hold_cnt[k] = '0;
              end
              // auto-repeat: restart at zero, no wrap
              if (hold_cnt[k] == rpt_ticks) begin
                press_pend[k] = 1'b1;
                hold_cnt[k]   = '0;
              end
            end
            default: ;
          endcase
        end
        prev_lvl[k] = s;
      end
    end else if (op == OP_TEST_PRESS || op == OP_TEST_LONG) begin
      if ((op == OP_TEST_PRESS) ? press_pend[key] : long_pend[key]) begin
        hit        = 1'b1;
        press_pend = '0;
        long_pend  = '0;
      end
    end
    res.press = press_pend;
    res.lng   = long_pend;
    res.hit   = hit;
    return res;
  endfunction

  // ---------------------------------------------------------------------
  // Queues and scoreboard
  // ---------------------------------------------------------------------
  keypad_item_t keypad_q[$];      // transactions still to be offered
  flag_set_t    want_flags_q[$];  // predicted results, oldest first
  flag_set_t    head_flags;
  int           err_count = 0;
  bit           in_accepted = 1'b0;

  task automatic report_mismatch(string fld, logic [FlagsW-1:0] got,
                                 logic [FlagsW-1:0] exp);
    if (err_count < 100)
      $display("tb_top: mismatch on %s: got %h, expected %h", fld, got, exp);
    err_count++;
  endtask

  // Input acceptance and result checking, both at the rising edge.
  always @(posedge clk_i) begin
    if (rst_ni && pop && !empty) begin
      if (want_flags_q.size() == 0) begin
        report_mismatch("unexpected result", press_flags_o, '0);
      end else begin
        head_flags = want_flags_q.pop_front();
        if (press_flags_o !== head_flags.press)
          report_mismatch("press_flags", press_flags_o, head_flags.press);
        if (long_flags_o !== head_flags.lng)
          report_mismatch("long_flags", long_flags_o, head_flags.lng);
        if (hit_o !== head_flags.hit)
          report_mismatch("hit", FlagsW'(hit_o), FlagsW'(head_flags.hit));
        if (beep_o !== head_flags.hit)
          report_mismatch("beep", FlagsW'(beep_o), FlagsW'(head_flags.hit));
      end
    end
    in_accepted = rst_ni && push && !full;
    if (in_accepted)
      want_flags_q.push_back(next_flags(op_e'(operation_i), row_i,
                                        column_levels_i, key_i));
  end

  // ---------------------------------------------------------------------
  // Driver: offers transactions at the falling edge, random gaps between
  // ---------------------------------------------------------------------
  int           gap_left = 0;
  bit           tx_stream = 1'b0;
  keypad_item_t cur_item;

  function automatic int draw_gap();
    int r;
    if (tx_stream) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      push <= 1'b0;
    end else if (!push || in_accepted) begin
      if ($urandom_range(0, 63) == 0) tx_stream = !tx_stream;
      if (gap_left > 0) begin
        gap_left--;
        push <= 1'b0;
      end else if (keypad_q.size() > 0) begin
        cur_item = keypad_q.pop_front();
        operation_i     <= cur_item.op;
        row_i           <= cur_item.row;
        column_levels_i <= cur_item.lv;
        key_i           <= cur_item.key;
        push            <= 1'b1;
        gap_left        = draw_gap();
      end else begin
        push <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Receiver: random pop with short and long stalls, plus one forced
  // long hold-off so the input side backs up
  // ---------------------------------------------------------------------
  int stall_left = 0;
  bit rx_stream  = 1'b0;
  bit stall_req  = 1'b0;
  bit stall_seen = 1'b0;

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      pop <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      pop <= 1'b0;
    end else if (stall_req != stall_seen) begin
      stall_seen = stall_req;
      stall_left = BigStall;
      pop <= 1'b0;
    end else begin
      if ($urandom_range(0, 255) == 0) rx_stream = !rx_stream;
      if (!rx_stream && $urandom_range(0, 47) == 0) begin
        stall_left = $urandom_range(8, 30);
        pop <= 1'b0;
      end else begin
        pop <= rx_stream || ($urandom_range(0, 3) != 0);
      end
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------
  int phase_items;

  task automatic add_item(op_e op, int row, int lv, int key);
    keypad_item_t it;
    it.op  = op;
    it.row = RowW'(row);
    it.lv  = LevelsW'(lv);
    it.key = KeyW'(key);
    keypad_q.push_back(it);
    phase_items++;
  endtask

  task automatic add_query(int row_hint);
    op_e q;
    int  key;
    q   = ($urandom_range(0, 1) != 0) ? OP_TEST_PRESS : OP_TEST_LONG;
    key = (row_hint >= 0 && $urandom_range(0, 1) != 0) ?
          row_hint * KeyColsDef + $urandom_range(0, KeyColsDef - 1) :
          $urandom_range(0, NumKeys - 1);
    add_item(q, $urandom_range(0, 3), $urandom_range(0, 15), key);
  endtask

  // Hold some keys of one row for a random number of scans, then mostly release.
  task automatic add_hold(int lim);
    int row;
    int lv;
    int n;
    row = $urandom_range(0, KeyRowsDef - 1);
    lv  = $urandom_range(0, 15);
    if (lv == 15) lv = 0;
    n   = $urandom_range(1, lim);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 15) == 0)
        // contact bounce on one column
        add_item(OP_SCAN, row, lv ^ (1 << $urandom_range(0, 3)),
                 $urandom_range(0, 15));
      else
        add_item(OP_SCAN, row, lv, $urandom_range(0, 15));
      if ($urandom_range(0, 9) == 0) begin
        if ($urandom_range(0, 1) != 0) add_query(row);
        else add_item(OP_SCAN, $urandom_range(0, 3), $urandom_range(0, 15),
                      $urandom_range(0, 15));
      end
    end
    if ($urandom_range(0, 7) != 0) begin
      add_item(OP_SCAN, row, 15, $urandom_range(0, 15));
      add_item(OP_SCAN, row, 15, $urandom_range(0, 15));
    end
    for (int i = $urandom_range(0, 3); i > 0; i--) add_query(row);
  endtask

  task automatic add_random_phase();
    int lim;
    int r;
    lim = int'(long_ticks) + 2 * int'(rpt_ticks) + 6;
    if (lim > 600) lim = 600;
    while (phase_items < PhaseItems) begin
      r = $urandom_range(0, 9);
      if (r < 6) begin
        add_hold(lim);
      end else if (r < 8) begin
        for (int i = $urandom_range(1, 3); i > 0; i--) add_query(-1);
      end else if (r < 9) begin
        add_item(OP_SCAN, $urandom_range(0, 3), $urandom_range(0, 15),
                 $urandom_range(0, 15));
      end else begin
        add_item(op_e'($urandom_range(0, 3)), $urandom_range(0, 3),
                 $urandom_range(0, 15), $urandom_range(0, 15));
      end
    end
  endtask

  // Sender stops until every predicted result has been popped.
  task automatic wait_drained();
    while (keypad_q.size() != 0 || push || want_flags_q.size() != 0)
      @(negedge clk_i);
    repeat (6) @(negedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, int val);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= CfgW'(val);
    if (idx == CFG_LONG_PRESS) long_ticks = CountW'(val);
    else rpt_ticks = CountW'(val);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  int cfg_long [NumPhases] = '{150, 1, 255, 0, 2, 255, 0, 0, 0};
  int cfg_rpt  [NumPhases] = '{25, 1, 255, 0, 255, 1, 0, 0, 0};

  initial begin
    // last three settings: small random thresholds
    for (int p = 6; p < NumPhases; p++) begin
      cfg_long[p] = $urandom_range(1, 12);
      cfg_rpt[p]  = $urandom_range(1, 6);
    end
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    for (int p = 0; p < NumPhases; p++) begin
      if (p > 0) begin
        wait_drained();
        write_reg(CFG_LONG_PRESS, cfg_long[p]);
        write_reg(CFG_REPEAT, cfg_rpt[p]);
      end
      @(posedge clk_i);
      phase_items = 0;
      if (p == 0) begin
        // directed opener at reset thresholds
        add_item(OP_TEST_PRESS, 0, 0, 0);        // nothing pending: miss
        add_item(OP_TEST_LONG, 3, 15, 15);       // miss at top key
        add_item(OP_UNUSED, 3, 15, 15);          // unused code, all fields high
        add_item(OP_UNUSED, 0, 0, 0);
        add_item(OP_SCAN, 0, 0, 0);              // row 0 agrees with reset sample
        add_item(OP_SCAN, 0, 0, 0);
        add_item(OP_SCAN, 3, 15, 15);            // row 3 released, no step
        add_item(OP_SCAN, 3, 15, 15);
        add_item(OP_SCAN, 1, 10, 5);
        add_item(OP_SCAN, 1, 10, 10);
        add_item(OP_SCAN, 2, 5, 0);
        add_item(OP_SCAN, 2, 5, 0);
        add_item(OP_SCAN, 0, 15, 0);             // release edge, sample only
        add_item(OP_SCAN, 0, 15, 0);             // short press flagged, keys 0..3
        add_item(OP_TEST_LONG, 0, 0, 0);         // long not set: miss, flags kept
        add_item(OP_TEST_PRESS, 0, 0, 3);        // hit: clears all, beep
        add_item(OP_TEST_PRESS, 0, 0, 3);        // miss after clear
        add_item(OP_SCAN, 1, 15, 0);
        add_item(OP_SCAN, 1, 15, 0);             // row 1 releases: keys 4, 6
        add_item(OP_TEST_PRESS, 0, 0, 4);
        add_item(OP_TEST_PRESS, 0, 0, 15);
      end
      if (p == 1) stall_req = !stall_req;        // force a long receiver hold-off
      add_random_phase();
    end

    wait_drained();
    repeat (10) @(posedge clk_i);
    if (err_count == 0)
      $display("tb_top: done, clean");
    else
      $display("tb_top: done, errors");
    $finish;
  end

  // Watchdog, far beyond the slowest legal run
  initial begin
    #2000000;
    $display("tb_top: done, errors");
    $finish;
  end

endmodule

### keypad_debounce_long_press.f
hw/rtl/kdlp_pkg.sv
hw/rtl/kdlp_fifo.sv
hw/rtl/kdlp_front.sv
hw/rtl/kdlp_back.sv
hw/rtl/keypad_debounce_long_press.sv
hw/rtl/kdlp_checker.sv
sim/tb_top.sv
